// ===== rtl/core/taylor_sine_cosine_assert.svh =====
// Assertion macros used by the taylor_sine_cosine RTL.
`ifndef TAYLOR_SINE_COSINE_ASSERT_SVH
`define TAYLOR_SINE_COSINE_ASSERT_SVH
`ifndef SYNTH
`define TSC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("taylor_sine_cosine: same-cycle check failed");
`define TSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("taylor_sine_cosine: next-cycle check failed");
`else
`define TSC_ASSERT_IMPL(label, ante, cons)
`define TSC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/tsc_pkg.sv =====
// Shared types, constants and the reciprocal table of the taylor_sine_cosine block.
`default_nettype none
package tsc_pkg;

   localparam int ANGLE_W         = 32;
   localparam int ANGLE_FRAC_BITS = 28;
   localparam int WORK_FRAC       = 32;
   localparam int WORK_W          = 62;
   localparam int HALF_W          = 32;
   localparam int ACC_W           = 128;
   localparam int SUM_W           = 64;
   localparam int RCP_W           = 32;
   localparam int RESULT_W        = 32;
   localparam int COUNT_W         = 4;
   localparam int DEN_W           = 5;

   localparam logic [COUNT_W-1:0] MAX_TERMS        = 4'd10;
   localparam logic [COUNT_W-1:0] TERM_COUNT_RESET = 4'd8;

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   localparam logic [WORK_W-1:0] WORK_CAP   = {WORK_W{1'b1}};
   localparam logic [WORK_W-1:0] ONE_Q32    = WORK_W'(64'h1_0000_0000);
   localparam logic [ACC_W-1:0]  ROUND_INIT = ACC_W'(64'h8000_0000);

   typedef struct packed {
      logic                       op;
      logic signed [ANGLE_W-1:0]  angle;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic                       saturated;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [WORK_W-1:0] a;
      logic [WORK_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [WORK_W-1:0] prod;
   } mul_rsp_type;

   // Rounded 2^32 / (n * (n + 1)); denominators past 19 use the entry for 19.
   function automatic logic [RCP_W-1:0] rcp_lookup(input logic [DEN_W-1:0] den);
      logic [RCP_W-1:0] r;
      case (den)
         5'd0:    r = 32'd0;
         5'd1:    r = 32'd2147483648;
         5'd2:    r = 32'd715827883;
         5'd3:    r = 32'd357913941;
         5'd4:    r = 32'd214748365;
         5'd5:    r = 32'd143165577;
         5'd6:    r = 32'd102261126;
         5'd7:    r = 32'd76695845;
         5'd8:    r = 32'd59652324;
         5'd9:    r = 32'd47721859;
         5'd10:   r = 32'd39045157;
         5'd11:   r = 32'd32537631;
         5'd12:   r = 32'd27531842;
         5'd13:   r = 32'd23598721;
         5'd14:   r = 32'd20452225;
         5'd15:   r = 32'd17895697;
         5'd16:   r = 32'd15790321;
         5'd17:   r = 32'd14035841;
         5'd18:   r = 32'd12558384;
         default: r = 32'd11302546;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/taylor_sine_cosine.sv =====
// Top level of the taylor_sine_cosine block: sequencer, series sum and result rounding.
// From a start transfer to the rsp_valid strobe the block is busy; the time grows with the
// number of terms, and small angles take a little less. It takes the next start in the
// strobe cycle. The shared 32x32 multiplier sets that time: up to four partial products
// per Q32 product and two products per term. The receiver cannot stall. Synchronous reset
// loads 8 terms.
`default_nettype none
`include "taylor_sine_cosine_assert.svh"
module taylor_sine_cosine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tsc_pkg::req_type        req_data,
   output logic                    rsp_valid,
   output tsc_pkg::rsp_type        rsp_data,
   input  logic                    csr_we,
   input  logic [3:0]              csr_wdata
);
   import tsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_X2,
      S_ADD,
      S_MA,
      S_MB,
      S_ABS,
      S_OUT
   } state_type;

   localparam logic signed [SUM_W-1:0] SUM_CAP = SUM_W'(WORK_CAP);

   state_type                 state_ff;
   logic [COUNT_W-1:0]        term_count_ff;
   logic                      op_ff;
   logic                      base_neg_ff;
   logic [COUNT_W-1:0]        n_ff;
   logic [COUNT_W-1:0]        k_ff;
   logic [WORK_W-1:0]         term_ff;
   logic [WORK_W-1:0]         x2_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic                      neg_ff;
   logic [WORK_W:0]           mag_ff;
   logic                      flag_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;
   mul_req_type               mul_req_ff;
   mul_rsp_type               mul_rsp;

   logic                      angle_neg;
   logic [ANGLE_W-1:0]        angle_mag;
   logic [WORK_W-1:0]         xq;
   logic [COUNT_W-1:0]        terms_eff;
   logic                      term_neg;
   logic signed [SUM_W-1:0]   term_ext;
   logic signed [SUM_W-1:0]   sum_in;
   logic [DEN_W-1:0]          den;
   logic [SUM_W-1:0]          rnd_sum;
   logic [SUM_W-17:0]         rnd;
   logic                      out_clamp;
   logic [RESULT_W-1:0]       out_mag;

   tsc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   assign angle_neg = req_data.angle[ANGLE_W-1];
   assign angle_mag = angle_neg ? ANGLE_W'(-req_data.angle) : ANGLE_W'(req_data.angle);
   assign xq        = WORK_W'(angle_mag) << (WORK_FRAC - ANGLE_FRAC_BITS);
   assign terms_eff = (term_count_ff > MAX_TERMS) ? MAX_TERMS : term_count_ff;
   assign term_neg  = base_neg_ff ^ k_ff[0];
   assign term_ext  = SUM_W'(term_ff);
   assign sum_in    = term_neg ? (sum_ff - term_ext) : (sum_ff + term_ext);
   assign den       = (op_ff == OP_COSINE) ? {k_ff, 1'b1} : (DEN_W'({k_ff, 1'b0}) + 5'd2);

   assign rnd_sum = SUM_W'(mag_ff) + 64'h8000;
   assign rnd     = rnd_sum[SUM_W-1:16];

   always_comb begin
      if (neg_ff) begin
         out_clamp = rnd > 48'h0000_8000_0000;
         out_mag   = out_clamp ? 32'h8000_0000 : rnd[RESULT_W-1:0];
      end else begin
         out_clamp = rnd > 48'h0000_7FFF_FFFF;
         out_mag   = out_clamp ? 32'h7FFF_FFFF : rnd[RESULT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         term_count_ff    <= TERM_COUNT_RESET;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
      end else begin
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         if (csr_we) begin
            term_count_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff            <= req_data.op;
                  base_neg_ff      <= (req_data.op == OP_COSINE) ? 1'b0 : angle_neg;
                  n_ff             <= terms_eff;
                  k_ff             <= '0;
                  term_ff          <= (req_data.op == OP_COSINE) ? ONE_Q32 : xq;
                  sum_ff           <= '0;
                  flag_ff          <= 1'b0;
                  mul_req_ff.a     <= xq;
                  mul_req_ff.b     <= xq;
                  mul_req_ff.start <= 1'b1;
                  state_ff         <= S_X2;
               end
            end
            S_X2: begin
               if (mul_rsp.done) begin
                  x2_ff    <= mul_rsp.prod;
                  flag_ff  <= flag_ff | mul_rsp.ovf;
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (k_ff == n_ff) begin
                  state_ff <= S_ABS;
               end else begin
                  if (sum_in > SUM_CAP) begin
                     sum_ff  <= SUM_CAP;
                     flag_ff <= 1'b1;
                  end else if (sum_in < -SUM_CAP) begin
                     sum_ff  <= -SUM_CAP;
                     flag_ff <= 1'b1;
                  end else begin
                     sum_ff <= sum_in;
                  end
                  if ((k_ff + 4'd1) == n_ff) begin
                     state_ff <= S_ABS;
                  end else begin
                     mul_req_ff.a     <= term_ff;
                     mul_req_ff.b     <= x2_ff;
                     mul_req_ff.start <= 1'b1;
                     state_ff         <= S_MA;
                  end
               end
            end
            S_MA: begin
               if (mul_rsp.done) begin
                  flag_ff          <= flag_ff | mul_rsp.ovf;
                  mul_req_ff.a     <= mul_rsp.prod;
                  mul_req_ff.b     <= WORK_W'(rcp_lookup(den));
                  mul_req_ff.start <= 1'b1;
                  state_ff         <= S_MB;
               end
            end
            S_MB: begin
               if (mul_rsp.done) begin
                  flag_ff  <= flag_ff | mul_rsp.ovf;
                  term_ff  <= mul_rsp.prod;
                  k_ff     <= k_ff + 4'd1;
                  state_ff <= S_ADD;
               end
            end
            S_ABS: begin
               neg_ff   <= sum_ff[SUM_W-1];
               mag_ff   <= sum_ff[SUM_W-1] ? (WORK_W+1)'(-sum_ff) : (WORK_W+1)'(sum_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_ff.value     <= neg_ff ? RESULT_W'(-out_mag) : out_mag;
               rsp_ff.saturated <= flag_ff | out_clamp;
               rsp_valid_ff     <= 1'b1;
               state_ff         <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TSC_ASSERT_IMPL(a_rsp_when_idle, rsp_valid_ff, state_ff == S_IDLE)
   `TSC_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
   `TSC_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff)
   `TSC_ASSERT_IMPL(a_term_index_bound, state_ff != S_IDLE, k_ff <= n_ff && n_ff <= MAX_TERMS)

endmodule
`default_nettype wire

// ===== rtl/core/tsc_mul.sv =====
// Shared Q32 multiplier built from one 32x32 multiplier over up to four partial products.
`default_nettype none
`include "taylor_sine_cosine_assert.svh"
module tsc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  tsc_pkg::mul_req_type mul_req,
   output tsc_pkg::mul_rsp_type mul_rsp
);
   import tsc_pkg::*;

   logic                busy_ff;
   logic                issue_ff;
   logic                pvalid_ff;
   logic                done_ff;
   logic [1:0]          cnt_ff;
   logic [1:0]          last_ff;
   logic [1:0]          poff_ff;
   logic [2*HALF_W-1:0] p_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [WORK_W-1:0]   a_ff;
   logic [WORK_W-1:0]   b_ff;

   logic [HALF_W-1:0]   op_a;
   logic [HALF_W-1:0]   op_b;
   logic [2*HALF_W-1:0] part;
   logic [ACC_W-1:0]    shifted;
   logic                ovf;

   assign op_a = cnt_ff[0] ? HALF_W'(a_ff[WORK_W-1:HALF_W]) : a_ff[HALF_W-1:0];
   assign op_b = cnt_ff[1] ? HALF_W'(b_ff[WORK_W-1:HALF_W]) : b_ff[HALF_W-1:0];
   assign part = (2*HALF_W)'(op_a) * (2*HALF_W)'(op_b);

   always_comb begin
      case (poff_ff)
         2'd0:    shifted = ACC_W'(p_ff);
         2'd1:    shifted = ACC_W'(p_ff) << HALF_W;
         2'd2:    shifted = ACC_W'(p_ff) << (2*HALF_W);
         default: shifted = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         issue_ff  <= 1'b0;
         pvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            a_ff      <= mul_req.a;
            b_ff      <= mul_req.b;
            acc_ff    <= ROUND_INIT;
            cnt_ff    <= 2'd0;
            last_ff   <= (mul_req.b[WORK_W-1:HALF_W] == '0) ? 2'd1 : 2'd3;
            issue_ff  <= 1'b1;
            pvalid_ff <= 1'b0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (issue_ff) begin
               p_ff      <= part;
               poff_ff   <= {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
               pvalid_ff <= 1'b1;
               if (cnt_ff == last_ff) begin
                  issue_ff <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + 2'd1;
               end
            end else begin
               pvalid_ff <= 1'b0;
            end
            if (pvalid_ff) begin
               acc_ff <= acc_ff + shifted;
            end
            if (pvalid_ff && !issue_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign ovf          = |acc_ff[ACC_W-1:WORK_FRAC+WORK_W];
   assign mul_rsp.done = done_ff;
   assign mul_rsp.ovf  = ovf;
   assign mul_rsp.prod = ovf ? WORK_CAP : acc_ff[WORK_FRAC+WORK_W-1:WORK_FRAC];

   `TSC_ASSERT_IMPL(a_start_when_idle, mul_req.start, !busy_ff)
   `TSC_ASSERT_NEXT(a_done_single, done_ff, !done_ff)
   `TSC_ASSERT_IMPL(a_done_not_busy, done_ff, !busy_ff)

endmodule
`default_nettype wire
